>>> src/order_crossover_permutation_assert.svh
// Assertion macros for the order crossover block.
// Each check is sampled on clk and held off while rst_n is low.
`ifndef ORDER_CROSSOVER_PERMUTATION_ASSERT_SVH
`define ORDER_CROSSOVER_PERMUTATION_ASSERT_SVH

// Same-cycle implication.
`define OXC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order crossover check failed");

// Next-cycle implication.
`define OXC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order crossover check failed");

`endif

>>> src/oxc_pkg.sv
package oxc_pkg;

    localparam int MAX_CITIES = 64;
    localparam int CITY_W     = 7;
    localparam int POS_W      = $clog2(MAX_CITIES);
    localparam int CNT_W      = $clog2(MAX_CITIES + 1);
    localparam int DRAW_W     = 16;
    localparam int THR_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    typedef logic [CITY_W-1:0]     city_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [MAX_CITIES-1:0] bitmap_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CITY_COUNT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_THRESHOLD = 1'd1;

    localparam cnt_t              CITY_COUNT_RST = cnt_t'(MAX_CITIES);
    localparam logic [THR_W-1:0]  THRESHOLD_RST  = THR_W'(65536);

    typedef struct packed {
        pos_t  position;
        city_t child_one_city;
        city_t child_two_city;
        logic  crossed;
        logic  last_out;
    } result_t;

    // control from the sequencer to one fill unit
    typedef struct packed {
        logic  clear;
        logic  seg_valid;
        city_t seg_city;
        logic  scan_valid;
        city_t scan_city;
    } fill_ctl_t;

    typedef struct packed {
        logic  en;
        pos_t  addr;
        city_t data;
    } fill_wr_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } q_stat_t;

    function automatic logic city_known(input city_t c);
        return (c != '0) && (c <= city_t'(MAX_CITIES));
    endfunction

    function automatic bitmap_t city_bit(input city_t c);
        city_t idx;
        idx = c - city_t'(1);
        return city_known(c) ? (bitmap_t'(1) << idx[POS_W-1:0]) : '0;
    endfunction

endpackage

>>> src/oxc_in_if.sv
interface oxc_in_if;
    import oxc_pkg::*;

    logic              valid;
    logic              ready;
    city_t             a_city;
    city_t             b_city;
    logic              is_last;
    logic [DRAW_W-1:0] random_draw;
    pos_t              cut_low;
    pos_t              cut_high;

    modport source (output valid, a_city, b_city, is_last, random_draw, cut_low, cut_high,
                    input ready);
    modport sink   (input valid, a_city, b_city, is_last, random_draw, cut_low, cut_high,
                    output ready);
endinterface

>>> src/oxc_out_if.sv
interface oxc_out_if;
    import oxc_pkg::*;

    logic  valid;
    logic  ready;
    pos_t  position;
    city_t child_one_city;
    city_t child_two_city;
    logic  crossed;
    logic  last_out;

    modport source (output valid, position, child_one_city, child_two_city, crossed,
                    last_out, input ready);
    modport sink   (input valid, position, child_one_city, child_two_city, crossed,
                    last_out, output ready);
endinterface

>>> src/oxc_cfg_if.sv
interface oxc_cfg_if;
    import oxc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/oxc_ram.sv
module oxc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> src/oxc_fill.sv
module oxc_fill (
    input  logic              clk,
    input  logic              rst_n,
    input  oxc_pkg::fill_ctl_t ctl,
    input  oxc_pkg::cnt_t     n,
    input  oxc_pkg::pos_t     start,
    input  oxc_pkg::cnt_t     need,
    output oxc_pkg::fill_wr_t wr,
    output oxc_pkg::cnt_t     done
);
    import oxc_pkg::*;

    bitmap_t present_reg, present_next;
    cnt_t    done_reg, done_next;
    pos_t    ptr_reg, ptr_next;
    logic    scan_hit;
    logic    take;
    cnt_t    ptr_inc;

    // skip cities already in the child; stop once every free slot is used
    assign scan_hit = (present_reg & city_bit(ctl.scan_city)) != '0;
    assign take     = ctl.scan_valid && !scan_hit && (done_reg < need);
    assign ptr_inc  = {1'b0, ptr_reg} + cnt_t'(1);

    always_comb
    begin
        present_next = present_reg;
        done_next    = done_reg;
        ptr_next     = ptr_reg;
        wr.en        = 1'b0;
        wr.addr      = ptr_reg;
        wr.data      = ctl.scan_city;
        if (ctl.clear)
        begin
            present_next = '0;
            done_next    = '0;
            ptr_next     = start;
        end
        else
        begin
            if (ctl.seg_valid)
            begin
                present_next = present_next | city_bit(ctl.seg_city);
            end
            if (take)
            begin
                wr.en        = 1'b1;
                present_next = present_next | city_bit(ctl.scan_city);
                done_next    = done_reg + cnt_t'(1);
                ptr_next     = (ptr_inc == n) ? '0 : ptr_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            done_reg    <= '0;
            ptr_reg     <= '0;
        end
        else
        begin
            present_reg <= present_next;
            done_reg    <= done_next;
            ptr_reg     <= ptr_next;
        end
    end

    assign done = done_reg;
endmodule

>>> src/oxc_out_q.sv
module oxc_out_q (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  oxc_pkg::result_t   push_data,
    oxc_out_if.source          children,
    output oxc_pkg::q_stat_t   stat
);
    import oxc_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;
    result_t    head;

    assign pop  = children.valid && children.ready;
    assign head = entry_reg[rd_ptr_reg];

    assign children.valid          = count_reg != 2'd0;
    assign children.position       = head.position;
    assign children.child_one_city = head.child_one_city;
    assign children.child_two_city = head.child_two_city;
    assign children.crossed        = head.crossed;
    assign children.last_out       = head.last_out;

    assign stat.count = count_reg;
    assign stat.pop   = pop;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> src/order_crossover_permutation.sv
// Order crossover (OX1) of two parent tours of N cities (1..64). Parent pairs arrive one per
// transfer on "parents", one per cycle while the block is loading, and go into two 64-entry
// parent memories. The transfer marked is_last also carries the draw and the two cuts; cuts
// are clamped to 0 <= low <= high <= N-1, and the tour crosses when random_draw <
// cross_threshold. After that transfer the block takes no parent input until its reads are
// done: when crossing, a segment pass over positions low..high builds the two membership
// bitmaps, then a fill pass scans both donors together and writes the two child memories;
// then N results (positions 0..N-1, last_out on the final one) leave on "children" at up to
// one per cycle as the output queue has room. All passes share one read address, and each
// memory has a single read port. Free slots that the donor cannot fill (repeated cities)
// come out as city 0. The next tour may load while the last results still wait in the
// two-entry output queue. Configuration (city_count, cross_threshold) must be written only
// while the block is idle; the block itself does not enforce this. A city_count outside
// 1..64 is clamped. No clearing pass follows reset.
`include "order_crossover_permutation_assert.svh"

module order_crossover_permutation (
    input  logic       clk,
    input  logic       rst_n,
    oxc_in_if.sink     parents,
    oxc_out_if.source  children,
    oxc_cfg_if.sink    cfg
);
    import oxc_pkg::*;

    // sequencer phases, also used to tag reads in flight
    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SEG  = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    pos_t             addr_reg, addr_next;       // shared read address
    cnt_t             cnt_reg, cnt_next;         // reads issued in fill pass
    cnt_t             load_idx_reg, load_idx_next;
    cnt_t             city_count_reg;
    logic [THR_W-1:0] threshold_reg;

    // per-tour parameters, latched on the last transfer
    cnt_t n_reg;
    pos_t lo_reg, hi_reg, start_reg;
    cnt_t need_reg;
    logic crossed_reg;

    // read pipeline tag
    logic       rd_valid_reg;
    logic [1:0] rd_kind_reg;
    pos_t       rd_pos_reg;

    logic  in_xfer, load_we;
    cnt_t  n_calc, n_less;
    pos_t  hi_calc, lo_calc, start_calc;
    cnt_t  need_calc, hi_inc;
    logic  crossed_calc;

    logic  seg_issue, fill_issue, emit_issue, rd_issue;
    logic  fill_inflight, emit_inflight, q_room;
    cnt_t  addr_inc;

    city_t p1_rdata, p2_rdata, c1_rdata, c2_rdata;

    fill_ctl_t fill1_ctl, fill2_ctl;
    fill_wr_t  fill1_wr, fill2_wr;
    cnt_t      fill1_done, fill2_done;

    q_stat_t q_stat;
    logic    q_push;
    result_t q_data;
    cnt_t    pos_w, start_w, off;
    logic    in_seg, c1_filled, c2_filled;

    //--------------------------------------------------------------
    // configuration: always ready
    //--------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg <= CITY_COUNT_RST;
            threshold_reg  <= THRESHOLD_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_CITY_COUNT:      city_count_reg <= cfg.data[CNT_W-1:0];
                REG_CROSS_THRESHOLD: threshold_reg  <= cfg.data[THR_W-1:0];
                default:             ;
            endcase
        end
    end

    //--------------------------------------------------------------
    // tour setup from the last transfer
    //--------------------------------------------------------------
    assign parents.ready = state_reg == ST_LOAD;
    assign in_xfer       = parents.valid && parents.ready;
    // pairs beyond the memory depth are dropped
    assign load_we       = in_xfer && (load_idx_reg < cnt_t'(MAX_CITIES));

    always_comb
    begin
        if (city_count_reg == '0)
        begin
            n_calc = cnt_t'(1);
        end
        else if (city_count_reg > cnt_t'(MAX_CITIES))
        begin
            n_calc = cnt_t'(MAX_CITIES);
        end
        else
        begin
            n_calc = city_count_reg;
        end
    end

    assign n_less     = n_calc - cnt_t'(1);
    assign hi_calc    = ({1'b0, parents.cut_high} > n_less) ? n_less[POS_W-1:0]
                                                              : parents.cut_high;
    assign lo_calc    = (parents.cut_low > hi_calc) ? hi_calc : parents.cut_low;
    assign hi_inc     = {1'b0, hi_calc} + cnt_t'(1);
    // fill starts just after the second cut, wrapping at N
    assign start_calc = (hi_inc == n_calc) ? '0 : hi_inc[POS_W-1:0];
    assign need_calc  = n_calc - {1'b0, hi_calc} + {1'b0, lo_calc} - cnt_t'(1);
    assign crossed_calc = {1'b0, parents.random_draw} < threshold_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer && parents.is_last)
        begin
            n_reg       <= n_calc;
            lo_reg      <= lo_calc;
            hi_reg      <= hi_calc;
            start_reg   <= start_calc;
            need_reg    <= need_calc;
            crossed_reg <= crossed_calc;
        end
    end

    //--------------------------------------------------------------
    // sequencer
    //--------------------------------------------------------------
    assign fill_inflight = rd_valid_reg && (rd_kind_reg == ST_FILL);
    assign emit_inflight = rd_valid_reg && (rd_kind_reg == ST_EMIT);

    // credit check against the two-entry output queue, counting a read in flight
    assign q_room = (q_stat.count == 2'd0)
                 || ((q_stat.count == 2'd1) && (!emit_inflight || q_stat.pop))
                 || ((q_stat.count == 2'd2) && q_stat.pop && !emit_inflight);

    assign seg_issue  = state_reg == ST_SEG;
    assign fill_issue = state_reg == ST_FILL;
    // interlock: the final fill write may hit the first slot read for output
    assign emit_issue = (state_reg == ST_EMIT) && q_room && !fill_inflight;
    assign rd_issue   = seg_issue || fill_issue || emit_issue;
    assign addr_inc   = {1'b0, addr_reg} + cnt_t'(1);

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        load_idx_next = load_idx_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_we)
                begin
                    load_idx_next = load_idx_reg + cnt_t'(1);
                end
                if (in_xfer && parents.is_last)
                begin
                    load_idx_next = '0;
                    state_next    = crossed_calc ? ST_SEG : ST_EMIT;
                    addr_next     = crossed_calc ? lo_calc : '0;
                end
            end
            ST_SEG:
            begin
                if (addr_reg == hi_reg)
                begin
                    state_next = ST_FILL;
                    addr_next  = start_reg;
                    cnt_next   = '0;
                end
                else
                begin
                    addr_next = addr_inc[POS_W-1:0];
                end
            end
            ST_FILL:
            begin
                cnt_next  = cnt_reg + cnt_t'(1);
                addr_next = (addr_inc == n_reg) ? '0 : addr_inc[POS_W-1:0];
                if (cnt_reg == n_reg - cnt_t'(1))
                begin
                    state_next = ST_EMIT;
                    addr_next  = '0;
                end
            end
            ST_EMIT:
            begin
                if (emit_issue)
                begin
                    addr_next = addr_inc[POS_W-1:0];
                    if (addr_inc == n_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            addr_reg     <= '0;
            cnt_reg      <= '0;
            load_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_kind_reg  <= ST_LOAD;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            cnt_reg      <= cnt_next;
            load_idx_reg <= load_idx_next;
            rd_valid_reg <= rd_issue;
            rd_kind_reg  <= state_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg <= addr_reg;
    end

    //--------------------------------------------------------------
    // parent and child memories
    //--------------------------------------------------------------
    oxc_ram #(.DEPTH(MAX_CITIES), .WIDTH(CITY_W)) u_parent_one (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_idx_reg[POS_W-1:0]),
        .wdata (parents.a_city),
        .re    (rd_issue),
        .raddr (addr_reg),
        .rdata (p1_rdata)
    );

    oxc_ram #(.DEPTH(MAX_CITIES), .WIDTH(CITY_W)) u_parent_two (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_idx_reg[POS_W-1:0]),
        .wdata (parents.b_city),
        .re    (rd_issue),
        .raddr (addr_reg),
        .rdata (p2_rdata)
    );

    oxc_ram #(.DEPTH(MAX_CITIES), .WIDTH(CITY_W)) u_child_one (
        .clk   (clk),
        .we    (fill1_wr.en),
        .waddr (fill1_wr.addr),
        .wdata (fill1_wr.data),
        .re    (emit_issue),
        .raddr (addr_reg),
        .rdata (c1_rdata)
    );

    oxc_ram #(.DEPTH(MAX_CITIES), .WIDTH(CITY_W)) u_child_two (
        .clk   (clk),
        .we    (fill2_wr.en),
        .waddr (fill2_wr.addr),
        .wdata (fill2_wr.data),
        .re    (emit_issue),
        .raddr (addr_reg),
        .rdata (c2_rdata)
    );

    //--------------------------------------------------------------
    // fill units: own parent marks the segment, other parent donates
    //--------------------------------------------------------------
    always_comb
    begin
        fill1_ctl.clear      = seg_issue && (addr_reg == lo_reg);
        fill1_ctl.seg_valid  = rd_valid_reg && (rd_kind_reg == ST_SEG);
        fill1_ctl.seg_city   = p1_rdata;
        fill1_ctl.scan_valid = fill_inflight;
        fill1_ctl.scan_city  = p2_rdata;

        fill2_ctl.clear      = fill1_ctl.clear;
        fill2_ctl.seg_valid  = fill1_ctl.seg_valid;
        fill2_ctl.seg_city   = p2_rdata;
        fill2_ctl.scan_valid = fill_inflight;
        fill2_ctl.scan_city  = p1_rdata;
    end

    oxc_fill u_fill_one (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fill1_ctl),
        .n     (n_reg),
        .start (start_reg),
        .need  (need_reg),
        .wr    (fill1_wr),
        .done  (fill1_done)
    );

    oxc_fill u_fill_two (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fill2_ctl),
        .n     (n_reg),
        .start (start_reg),
        .need  (need_reg),
        .wr    (fill2_wr),
        .done  (fill2_done)
    );

    //--------------------------------------------------------------
    // result assembly: an uncrossed tour copies its parents; when crossed,
    // the segment comes from the own parent, filled slots from the child
    // memory, and slots past the fill count are empty
    assign pos_w   = {1'b0, rd_pos_reg};
    assign start_w = {1'b0, start_reg};
    assign off     = (pos_w >= start_w) ? (pos_w - start_w) : (pos_w + n_reg - start_w);
    assign in_seg  = (rd_pos_reg >= lo_reg) && (rd_pos_reg <= hi_reg);
    assign c1_filled = off < fill1_done;
    assign c2_filled = off < fill2_done;

    assign q_push = emit_inflight;

    always_comb
    begin
        q_data.position = rd_pos_reg;
        q_data.crossed  = crossed_reg;
        q_data.last_out = (pos_w + cnt_t'(1)) == n_reg;
        if (!crossed_reg || in_seg)
        begin
            q_data.child_one_city = p1_rdata;
            q_data.child_two_city = p2_rdata;
        end
        else
        begin
            q_data.child_one_city = c1_filled ? c1_rdata : '0;
            q_data.child_two_city = c2_filled ? c2_rdata : '0;
        end
    end

    oxc_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .children  (children),
        .stat      (q_stat)
    );

    //--------------------------------------------------------------
    // checks
    //--------------------------------------------------------------
    `OXC_ASSERT_IMPL(a_q_no_overflow, q_push && (q_stat.count == 2'd2), q_stat.pop)
    `OXC_ASSERT_IMPL(a_fill_bound,
        crossed_reg && ((state_reg == ST_FILL) || (state_reg == ST_EMIT)),
        (fill1_done <= need_reg) && (fill2_done <= need_reg))
    `OXC_ASSERT_IMPL(a_load_quiet, in_xfer,
        !(rd_valid_reg && ((rd_kind_reg == ST_SEG) || (rd_kind_reg == ST_FILL))))
    `OXC_ASSERT_NEXT(a_last_leaves_load, in_xfer && parents.is_last, state_reg != ST_LOAD)

endmodule
